>>> hw/rtl/svpt_pkg.sv
// package for the pan/tilt servo positioner: command and register codes,
// request and result types, the degree-to-duty table builder
// no dependencies
package svpt_pkg;

  localparam int unsigned DUTY_BITS_DEFAULT = 14;

  localparam int unsigned DEG_MAX       = 180;
  localparam int unsigned TRAVEL_MAX    = 90;
  localparam int unsigned PULSE_MIN_US  = 500;
  localparam int unsigned PULSE_SPAN_US = 2000;
  localparam int unsigned FRAME_US      = 20000;

  localparam logic [7:0]  POS_RESET     = 8'd90;
  localparam logic        ENABLE_RESET  = 1'b1;
  localparam logic [6:0]  X_TRAVEL_RESET = 7'd25;
  localparam logic [6:0]  Y_TRAVEL_RESET = 7'd45;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  typedef enum logic [1:0] {
    CMD_MOVE   = 2'd0,
    CMD_CENTER = 2'd1,
    CMD_ADJUST = 2'd2,
    CMD_TICK   = 2'd3
  } svpt_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE   = 2'd0,
    REG_X_TRAVEL = 2'd1,
    REG_Y_TRAVEL = 2'd2
  } svpt_reg_e;

  typedef struct packed {
    svpt_cmd_e          command;
    logic signed [8:0]  pan_delta;
    logic signed [8:0]  tilt_delta;
    logic [15:0]        step_period;
  } svpt_item_t;

  typedef struct packed {
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [15:0] duty_x;
    logic [15:0] duty_y;
    logic        duty_update;
    logic        moving;
  } svpt_result_t;

  typedef logic [15:0] duty_tbl_t [256];

  // built at elaboration; codes above full scale read as full scale
  function automatic duty_tbl_t duty_table(input int unsigned bits);
    duty_tbl_t   tbl;
    int unsigned maxv;
    int unsigned deg;
    int unsigned pulse;
    maxv = (32'd1 << bits) - 32'd1;
    for (int i = 0; i < 256; i++) begin
      deg    = (i > DEG_MAX) ? DEG_MAX : i;
      pulse  = PULSE_MIN_US + deg * PULSE_SPAN_US / DEG_MAX;
      tbl[i] = 16'((pulse * maxv) / FRAME_US);
    end
    return tbl;
  endfunction

endpackage

>>> hw/rtl/svpt_in_stage.sv
// input register for the servo positioner: holds one request until the
// core takes it
// depends on svpt_pkg
module svpt_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  svpt_pkg::svpt_item_t in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output svpt_pkg::svpt_item_t out_item_o
);
  import svpt_pkg::*;

  logic       valid_q;
  svpt_item_t item_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

>>> hw/rtl/svpt_core.sv
// servo positioner core: config registers, position/goal/center state,
// next-state logic and duty lookup for one request
// depends on svpt_pkg
module svpt_core #(
  parameter int unsigned DUTY_BITS = svpt_pkg::DUTY_BITS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [svpt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [svpt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          fire_i,
  input  svpt_pkg::svpt_item_t          item_i,
  output svpt_pkg::svpt_result_t        result_o
);
  import svpt_pkg::*;

  localparam duty_tbl_t DutyTbl = duty_table(DUTY_BITS);

  logic       en_q;
  logic [6:0] x_trav_q, y_trav_q;
  logic [7:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [7:0] goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  logic [7:0] ctr_x_q, ctr_x_d, ctr_y_q, ctr_y_d;
  logic [15:0] period_q, period_d, tick_q, tick_d;

  logic [6:0]  tx, ty;
  logic [16:0] tick_next;
  logic        at_goal;
  logic        step;

  function automatic logic signed [10:0] u8_s(input logic [7:0] v);
    return $signed({3'b000, v});
  endfunction

  function automatic logic signed [10:0] clamp(input logic signed [10:0] v,
                                               input logic signed [10:0] lo,
                                               input logic signed [10:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // new goal for a move: position plus offset, kept within center +/- travel and 0..DEG_MAX
  function automatic logic [7:0] move_goal(input logic [7:0] pos,
                                           input logic signed [8:0] off,
                                           input logic [7:0] ctr,
                                           input logic [6:0] tr);
    logic signed [10:0] sum;
    logic signed [10:0] lo;
    logic signed [10:0] hi;
    logic signed [10:0] v;
    sum = u8_s(pos) + {{2{off[8]}}, off};
    lo  = u8_s(ctr) - $signed({4'b0000, tr});
    hi  = u8_s(ctr) + $signed({4'b0000, tr});
    v   = clamp(clamp(sum, lo, hi), 11'sd0, 11'(DEG_MAX));
    return v[7:0];
  endfunction

  function automatic logic [7:0] adj_center(input logic [7:0] ctr,
                                            input logic signed [8:0] off,
                                            input logic [6:0] tr);
    logic signed [10:0] v;
    v = clamp(u8_s(ctr) + {{2{off[8]}}, off}, $signed({4'b0000, tr}),
              11'(DEG_MAX) - $signed({4'b0000, tr}));
    return v[7:0];
  endfunction

  function automatic logic [7:0] step_toward(input logic [7:0] p,
                                             input logic [7:0] g);
    if (p < g) return p + 8'd1;
    if (p > g) return p - 8'd1;
    return p;
  endfunction

  assign tx        = (x_trav_q > 7'(TRAVEL_MAX)) ? 7'(TRAVEL_MAX) : x_trav_q;
  assign ty        = (y_trav_q > 7'(TRAVEL_MAX)) ? 7'(TRAVEL_MAX) : y_trav_q;
  assign tick_next = {1'b0, tick_q} + 17'd1;
  assign at_goal   = (pos_x_q == goal_x_q) && (pos_y_q == goal_y_q);

  always_comb begin
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    goal_x_d = goal_x_q;
    goal_y_d = goal_y_q;
    ctr_x_d  = ctr_x_q;
    ctr_y_d  = ctr_y_q;
    period_d = period_q;
    tick_d   = tick_q;
    step     = 1'b0;
    case (item_i.command)
      CMD_MOVE: begin
        if (en_q) begin
          goal_x_d = move_goal(pos_x_q, item_i.pan_delta, ctr_x_q, tx);
          goal_y_d = move_goal(pos_y_q, item_i.tilt_delta, ctr_y_q, ty);
          period_d = item_i.step_period;
          tick_d   = '0;
        end
      end
      CMD_CENTER: begin
        if (en_q) begin
          goal_x_d = ctr_x_q;
          goal_y_d = ctr_y_q;
          period_d = item_i.step_period;
          tick_d   = '0;
        end
      end
      CMD_ADJUST: begin
        ctr_x_d = adj_center(ctr_x_q, item_i.pan_delta, tx);
        ctr_y_d = adj_center(ctr_y_q, item_i.tilt_delta, ty);
        if (en_q) begin
          goal_x_d = ctr_x_d;
          goal_y_d = ctr_y_d;
          period_d = item_i.step_period;
          tick_d   = '0;
        end
      end
      CMD_TICK: begin
        if (!at_goal) begin
          // a zero period steps on every tick
          if (tick_next >= {1'b0, period_q}) begin
            pos_x_d = step_toward(pos_x_q, goal_x_q);
            pos_y_d = step_toward(pos_y_q, goal_y_q);
            tick_d  = '0;
            step    = 1'b1;
          end else begin
            tick_d = tick_next[15:0];
          end
        end else begin
          tick_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result_o.pos_x       = pos_x_d;
    result_o.pos_y       = pos_y_d;
    result_o.duty_x      = DutyTbl[pos_x_d];
    result_o.duty_y      = DutyTbl[pos_y_d];
    result_o.duty_update = step;
    result_o.moving      = (pos_x_d != goal_x_d) || (pos_y_d != goal_y_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= ENABLE_RESET;
      x_trav_q <= X_TRAVEL_RESET;
      y_trav_q <= Y_TRAVEL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ENABLE:   en_q     <= cfg_data_i[0];
        REG_X_TRAVEL: x_trav_q <= cfg_data_i;
        REG_Y_TRAVEL: y_trav_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q  <= POS_RESET;
      pos_y_q  <= POS_RESET;
      goal_x_q <= POS_RESET;
      goal_y_q <= POS_RESET;
      ctr_x_q  <= POS_RESET;
      ctr_y_q  <= POS_RESET;
      period_q <= '0;
      tick_q   <= '0;
    end else if (fire_i) begin
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
      goal_x_q <= goal_x_d;
      goal_y_q <= goal_y_d;
      ctr_x_q  <= ctr_x_d;
      ctr_y_q  <= ctr_y_d;
      period_q <= period_d;
      tick_q   <= tick_d;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_x_q <= 8'(DEG_MAX) && pos_y_q <= 8'(DEG_MAX))
    else $error("position beyond full scale");

  a_tick_below_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q == 16'd0 || tick_q < period_q)
    else $error("tick count reached the period without a step");

  a_slew_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (pos_x_q == $past(pos_x_q) || pos_x_q == $past(pos_x_q) + 8'd1 ||
         pos_x_q == $past(pos_x_q) - 8'd1))
    else $error("pan moved more than one degree per request");

  a_step_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && step |-> item_i.command == CMD_TICK)
    else $error("step on a non-tick request");

  a_step_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && step |=> !$stable({pos_x_q, pos_y_q}))
    else $error("step reported but position unchanged");

endmodule

>>> hw/rtl/svpt_out_stage.sv
// result register for the servo positioner: holds one result until the
// downstream side takes it
// depends on svpt_pkg
module svpt_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  svpt_pkg::svpt_result_t in_result_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output svpt_pkg::svpt_result_t out_result_o
);
  import svpt_pkg::*;

  logic         valid_q;
  svpt_result_t result_q;

  assign in_ready_o   = !valid_q || out_ready_i;
  assign out_valid_o  = valid_q;
  assign out_result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      result_q <= in_result_i;
    end
  end

endmodule

>>> hw/rtl/servo_pan_tilt_slew_positioner_top.sv
// top level of the two-axis servo positioner with slew limit
// depends on svpt_pkg, svpt_in_stage, svpt_core, svpt_out_stage
//
//   channel   direction  handshake                  payload
//   s_axis    in         s_axis_tvalid/tready       tuser: command; tdata: offsets, period
//   m_axis    out        m_axis_tvalid/tready       tdata: positions, duties, flags
//   cfg       in         cfg_we_i (no back-pressure) cfg_idx_i, cfg_data_i
//
// one request per cycle sustained while m_axis takes results; a taken request passes
// through the input register, then next-state logic and duty table into the
// result register
// reset loads positions, goals and centers to mid-scale; no clearing pass
// a stalled m_axis holds its result and back-pressures s_axis through both registers
module servo_pan_tilt_slew_positioner_top #(
  parameter int unsigned DUTY_BITS = svpt_pkg::DUTY_BITS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [8:0] pan_delta, [17:9] tilt_delta, [33:18] step_period, [39:34] zero
  input  logic [svpt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] command
  input  logic [svpt_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] pos_x, [15:8] pos_y, [31:16] duty_x, [47:32] duty_y,
  // [48] duty_update, [49] moving, [55:50] zero
  output logic [svpt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [svpt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [svpt_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import svpt_pkg::*;

  svpt_item_t   s_item, core_item;
  svpt_result_t core_result, out_result;
  logic         core_valid, core_ready;
  logic         fire;

  always_comb begin
    s_item.command     = svpt_cmd_e'(s_axis_tuser[1:0]);
    s_item.pan_delta   = s_axis_tdata[8:0];
    s_item.tilt_delta  = s_axis_tdata[17:9];
    s_item.step_period = s_axis_tdata[33:18];
  end

  svpt_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (s_item),
    .out_valid_o (core_valid),
    .out_ready_i (core_ready),
    .out_item_o  (core_item)
  );

  assign fire = core_valid && core_ready;

  svpt_core #(
    .DUTY_BITS (DUTY_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .item_i     (core_item),
    .result_o   (core_result)
  );

  svpt_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (core_valid),
    .in_ready_o   (core_ready),
    .in_result_i  (core_result),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_result_o (out_result)
  );

  assign m_axis_tdata = {6'b000000, out_result.moving, out_result.duty_update,
                         out_result.duty_y, out_result.duty_x,
                         out_result.pos_y, out_result.pos_x};

endmodule
